>>> rtl/cmfr_pkg.sv
// cmfr_pkg: shared types, codes and constants for the clock module frequency block
// used by cmfr_dco_table, cmfr_clk_calc and clock_module_frequency_registers
// no dependencies
package cmfr_pkg;

  // table geometry and default sizes
  localparam int DCO_STEPS     = 8;
  localparam int STEP_W        = 3;
  localparam int DCO_ROWS_DEF  = 16;
  localparam int FREQ_BITS_DEF = 32;

  // config port
  localparam int PADDR_W = 4;
  localparam logic [1:0] CFG_PLUS = 2'd0;
  localparam logic [1:0] CFG_XHM  = 2'd1;
  localparam logic [1:0] CFG_VLO  = 2'd2;

  // item commands
  localparam logic [3:0] CMD_READ     = 4'd0;
  localparam logic [3:0] CMD_WRITE    = 4'd1;
  localparam logic [3:0] CMD_SET_XT1  = 4'd2;
  localparam logic [3:0] CMD_SET_XT2  = 4'd3;
  localparam logic [3:0] CMD_CPUOFF   = 4'd4;
  localparam logic [3:0] CMD_SCG1     = 4'd5;
  localparam logic [3:0] CMD_SOFT_RST = 4'd6;
  localparam logic [3:0] CMD_POR_RST  = 4'd7;
  localparam logic [3:0] CMD_LOAD     = 4'd8;

  // register addresses
  localparam logic [1:0] REG_DCOCTL = 2'd0;
  localparam logic [1:0] REG_CTL1   = 2'd1;
  localparam logic [1:0] REG_CTL2   = 2'd2;
  localparam logic [1:0] REG_CTL3   = 2'd3;

  // register reset values and fields
  localparam logic [7:0] DCOCTL_RST     = 8'h60;
  localparam logic [7:0] CTL1_RST_PLUS  = 8'h87;
  localparam logic [3:0] CTL1_POR_HI    = 4'h8;
  localparam logic [3:0] RSEL_RST_PLUS  = 4'h7;
  localparam logic [3:0] RSEL_RST_BASIC = 4'h4;
  localparam logic [7:0] CTL2_RST       = 8'h00;
  localparam logic [7:0] CTL3_RST       = 8'h04;
  localparam logic [7:0] XT2OF_MASK     = 8'h02;

  // oscillator limits
  localparam logic [31:0] LF_WATCH_HZ = 32'd32768;
  localparam logic [31:0] LF_EXT_LO   = 32'd10000;
  localparam logic [31:0] LF_EXT_HI   = 32'd50000;
  localparam logic [14:0] VLO_RST     = 15'd12000;

  typedef struct packed {
    logic [3:0]  command;
    logic [1:0]  reg_addr;
    logic [7:0]  write_data;
    logic [31:0] freq_hz;
    logic        xt2_connected;
    logic        gate_level;
    logic [3:0]  table_row;
    logic [2:0]  table_step;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [31:0] aux_clock_hz;
    logic [31:0] main_clock_hz;
    logic [31:0] submain_clock_hz;
    logic        fault_irq;
  } out_item_t;

  // settled state of one item, handed to the clock calculation
  typedef struct packed {
    logic [7:0]  read_data;
    logic [31:0] lf_hz;
    logic [31:0] x2_hz;
    logic        xt2_present;
    logic [4:0]  mod;
    logic        step_last;
    logic [1:0]  div_a;
    logic [1:0]  sel_m;
    logic [1:0]  div_m;
    logic        sel_s;
    logic [1:0]  div_s;
    logic        cpu_off;
    logic        sub_off;
    logic        irq;
  } cmfr_ctl_t;

  // crystal range limits by range select
  function automatic logic [31:0] xt_range_lo(input logic [1:0] sel);
    logic [31:0] v;
    case (sel)
      2'd1:    v = 32'd1000000;
      2'd2:    v = 32'd3000000;
      default: v = 32'd400000;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] xt_range_hi(input logic [1:0] sel);
    logic [31:0] v;
    case (sel)
      2'd0:    v = 32'd1000000;
      2'd1:    v = 32'd3000000;
      default: v = 32'd16000000;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/clock_module_frequency_registers.sv
// clock_module_frequency_registers: clock module register block, top level
// holds the control registers and oscillator state; uses cmfr_dco_table, cmfr_clk_calc
// depends on cmfr_pkg
//
//   port group   direction  payload      handshake
//   in_*         input      in_item_t    in_valid / in_stall
//   out_*        output     out_item_t   out_valid / out_stall
//   p*           config     32-bit data  psel / penable / pwrite, pready tied high
//
// one item per cycle sustained while out_stall is low; each item passes the input register, then
// the state update with table read, then the result register
// register state updates at the second stage, so each item sees all earlier items
// rst_n is synchronous and active low; the table keeps its contents until loaded
// a stalled result holds the pipe only as far back as there are no bubbles
module clock_module_frequency_registers
  import cmfr_pkg::*;
#(
  parameter int DCO_ROWS  = DCO_ROWS_DEF,
  parameter int FREQ_BITS = FREQ_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int RW = $clog2(DCO_ROWS);
  localparam int AW = RW + STEP_W;

  // config registers
  logic        plus_r;
  logic        xhm_r;
  logic [14:0] vlo_r;

  // block state
  logic [7:0]  dco_r, dco_nxt;
  logic [7:0]  c1_r, c1_nxt;
  logic [7:0]  c2_r, c2_nxt;
  logic [7:0]  c3_r, c3_nxt;
  logic [31:0] xt1_r, xt1_nxt;
  logic [31:0] xt2_r, xt2_nxt;
  logic        pres_r, pres_nxt;
  logic        cpu_r, cpu_nxt;
  logic        sub_r, sub_nxt;
  logic        irq_r, irq_nxt;

  // pipeline
  logic      s1_v_r;
  in_item_t  s1_r;
  logic      s2_v_r;
  cmfr_ctl_t s2_r;
  cmfr_ctl_t ctl_nxt;
  logic      out_v_r;
  out_item_t out_r;
  out_item_t calc_out;
  logic      en_out, en2, en1;

  // evaluation signals
  logic           por;
  logic           irq_tmp;
  logic [7:0]     c3_set;
  logic           x2_in;
  logic           xts_ok;
  logic [31:0]    lf;
  logic [3:0]     rsel_full;
  logic [RW-1:0]  rsel;
  logic [2:0]     step;
  logic [2:0]     step_nx;
  logic [7:0]     rdata;

  // table port signals
  logic                 tbl_we;
  logic [AW-1:0]        tbl_wa;
  logic [AW-1:0]        tbl_ra0;
  logic [AW-1:0]        tbl_ra1;
  logic [FREQ_BITS-1:0] tbl_rd0;
  logic [FREQ_BITS-1:0] tbl_rd1;

  // config port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plus_r <= 1'b1;
      xhm_r  <= 1'b1;
      vlo_r  <= VLO_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        CFG_PLUS: plus_r <= pwdata[0];
        CFG_XHM:  xhm_r  <= pwdata[0];
        CFG_VLO:  vlo_r  <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      CFG_PLUS: prdata = {31'd0, plus_r};
      CFG_XHM:  prdata = {31'd0, xhm_r};
      CFG_VLO:  prdata = {17'd0, vlo_r};
      default:  prdata = 32'd0;
    endcase
  end

  // stage enables
  assign en_out   = !out_v_r || !out_stall;
  assign en2      = !s2_v_r || en_out;
  assign en1      = !s1_v_r || en2;
  assign in_stall = !en1;

  // register command effects
  assign por = (s1_r.command == CMD_POR_RST);

  always_comb begin
    dco_nxt  = dco_r;
    c1_nxt   = c1_r;
    c2_nxt   = c2_r;
    c3_nxt   = c3_r;
    xt1_nxt  = xt1_r;
    xt2_nxt  = xt2_r;
    pres_nxt = pres_r;
    cpu_nxt  = cpu_r;
    sub_nxt  = sub_r;
    irq_tmp  = irq_r;
    case (s1_r.command)
      CMD_WRITE: begin
        case (s1_r.reg_addr)
          REG_DCOCTL: dco_nxt = s1_r.write_data;
          REG_CTL1:   c1_nxt  = s1_r.write_data;
          REG_CTL2:   c2_nxt  = s1_r.write_data;
          default: begin
            if (plus_r) begin
              c3_nxt = {s1_r.write_data[7:2], c3_r[1:0]};
            end
          end
        endcase
      end
      CMD_SET_XT1: xt1_nxt = s1_r.freq_hz;
      CMD_SET_XT2: begin
        xt2_nxt  = s1_r.freq_hz;
        pres_nxt = s1_r.xt2_connected;
      end
      CMD_CPUOFF: cpu_nxt = s1_r.gate_level;
      CMD_SCG1:   sub_nxt = s1_r.gate_level;
      CMD_SOFT_RST, CMD_POR_RST: begin
        // xt2 fault alone drops the interrupt before the reset
        if (c3_r[1] && !c3_r[0]) begin
          irq_tmp = 1'b0;
        end
        dco_nxt = DCOCTL_RST;
        c1_nxt  = {(por ? CTL1_POR_HI : c1_r[7:4]),
                   (plus_r ? RSEL_RST_PLUS : RSEL_RST_BASIC)};
        c2_nxt  = (por || plus_r) ? CTL2_RST : {c2_r[7:4], 4'h0};
        c3_nxt  = por ? CTL3_RST : (CTL3_RST | {7'd0, c3_r[0]});
      end
      default: ;
    endcase
  end

  // xt2 fault flag and interrupt level
  always_comb begin
    x2_in  = (xt2_nxt >= xt_range_lo(c3_nxt[7:6])) &&
             (xt2_nxt <= xt_range_hi(c3_nxt[7:6]));
    c3_set = (x2_in || !pres_nxt) ? (c3_nxt & ~XT2OF_MASK) : (c3_nxt | XT2OF_MASK);
    irq_nxt = (c3_set != c3_nxt) ? (c3_set[1:0] != 2'b00) : irq_tmp;
  end

  // low-frequency source
  always_comb begin
    xts_ok = plus_r ? xhm_r : 1'b1;
    lf     = 32'd0;
    if (xts_ok && c1_nxt[6]) begin
      if (xt1_nxt >= xt_range_lo(c3_set[5:4]) && xt1_nxt <= xt_range_hi(c3_set[5:4])) begin
        lf = xt1_nxt;
      end
    end else begin
      case (c3_set[5:4])
        2'd0: lf = (xt1_nxt == LF_WATCH_HZ) ? xt1_nxt : 32'd0;
        2'd2: lf = {17'd0, vlo_r};
        2'd3: lf = (xt1_nxt >= LF_EXT_LO && xt1_nxt <= LF_EXT_HI) ? xt1_nxt : 32'd0;
        default: lf = 32'd0;
      endcase
    end
  end

  // read data after the item
  always_comb begin
    case (s1_r.reg_addr)
      REG_DCOCTL: rdata = dco_nxt;
      REG_CTL1:   rdata = c1_nxt;
      REG_CTL2:   rdata = c2_nxt;
      default:    rdata = plus_r ? c3_set : 8'd0;
    endcase
    if (s1_r.command != CMD_READ) begin
      rdata = 8'd0;
    end
  end

  // table row and step lookup
  always_comb begin
    rsel_full = plus_r ? c1_nxt[3:0] : {1'b0, c1_nxt[2:0]};
    if ({1'b0, rsel_full} >= 5'(DCO_ROWS)) begin
      rsel = RW'(DCO_ROWS - 1);
    end else begin
      rsel = rsel_full[RW-1:0];
    end
    step    = dco_nxt[7:5];
    step_nx = (step == 3'd7) ? step : step + 3'd1;
    tbl_ra0 = {rsel, step};
    tbl_ra1 = {rsel, step_nx};
    tbl_we  = en2 && s1_v_r && s1_r.command == CMD_LOAD &&
              ({1'b0, s1_r.table_row} < 5'(DCO_ROWS));
    tbl_wa  = {s1_r.table_row[RW-1:0], s1_r.table_step};
  end

  // control for the clock calculation
  always_comb begin
    ctl_nxt.read_data   = rdata;
    ctl_nxt.lf_hz       = lf;
    ctl_nxt.x2_hz       = x2_in ? xt2_nxt : 32'd0;
    ctl_nxt.xt2_present = pres_nxt;
    ctl_nxt.mod         = dco_nxt[4:0];
    ctl_nxt.step_last   = (step == 3'd7);
    ctl_nxt.div_a       = c1_nxt[5:4];
    ctl_nxt.sel_m       = c2_nxt[7:6];
    ctl_nxt.div_m       = c2_nxt[5:4];
    ctl_nxt.sel_s       = c2_nxt[3];
    ctl_nxt.div_s       = c2_nxt[2:1];
    ctl_nxt.cpu_off     = cpu_nxt;
    ctl_nxt.sub_off     = sub_nxt;
    ctl_nxt.irq         = irq_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dco_r  <= DCOCTL_RST;
      c1_r   <= CTL1_RST_PLUS;
      c2_r   <= CTL2_RST;
      c3_r   <= CTL3_RST;
      xt1_r  <= 32'd0;
      xt2_r  <= 32'd0;
      pres_r <= 1'b0;
      cpu_r  <= 1'b0;
      sub_r  <= 1'b0;
      irq_r  <= 1'b0;
    end else if (en2 && s1_v_r) begin
      dco_r  <= dco_nxt;
      c1_r   <= c1_nxt;
      c2_r   <= c2_nxt;
      c3_r   <= c3_set;
      xt1_r  <= xt1_nxt;
      xt2_r  <= xt2_nxt;
      pres_r <= pres_nxt;
      cpu_r  <= cpu_nxt;
      sub_r  <= sub_nxt;
      irq_r  <= irq_nxt;
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en1) begin
        s1_v_r <= in_valid;
      end
      if (en2) begin
        s2_v_r <= s1_v_r;
      end
      if (en_out) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_r <= in_item;
    end
    if (en2) begin
      s2_r <= ctl_nxt;
    end
    if (en_out) begin
      out_r <= calc_out;
    end
  end

  cmfr_dco_table #(
    .DCO_ROWS  (DCO_ROWS),
    .FREQ_BITS (FREQ_BITS)
  ) u_table (
    .clk (clk),
    .we  (tbl_we),
    .wa  (tbl_wa),
    .wd  (FREQ_BITS'(s1_r.freq_hz)),
    .re  (en2),
    .ra0 (tbl_ra0),
    .ra1 (tbl_ra1),
    .rd0 (tbl_rd0),
    .rd1 (tbl_rd1)
  );

  cmfr_clk_calc #(
    .FREQ_BITS (FREQ_BITS)
  ) u_calc (
    .ctl    (s2_r),
    .t0     (tbl_rd0),
    .t1     (tbl_rd1),
    .result (calc_out)
  );

  assign out_valid = out_v_r;
  assign out_item  = out_r;

`ifndef NO_ASSERTIONS
  // an empty result register always lets the pipe take an item
  a_accept_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> !in_stall)
    else $error("input stalled with an empty result register");

  // xt2 fault flag never stands without an xt2 source
  a_xt2of_needs_source: assert property (@(posedge clk) disable iff (!rst_n)
    !pres_r |-> !c3_r[1])
    else $error("xt2 fault flag set without an xt2 source");

  // the interrupt only rises together with a fault flag
  a_irq_rise_has_flag: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(irq_r) |-> (c3_r[1:0] != 2'b00))
    else $error("interrupt rose with no fault flag set");

  // a table write only comes from an item that moves on
  a_table_write_owned: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |=> s2_v_r)
    else $error("table written by an item that did not advance");
`endif

endmodule

>>> rtl/cmfr_dco_table.sv
// cmfr_dco_table: DCO frequency table, one write port and two registered read ports
// a write in the same cycle as a read of that entry is forwarded
// depends on cmfr_pkg
module cmfr_dco_table
  import cmfr_pkg::*;
#(
  parameter int DCO_ROWS  = DCO_ROWS_DEF,
  parameter int FREQ_BITS = FREQ_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [$clog2(DCO_ROWS*DCO_STEPS)-1:0] wa,
  input  logic [FREQ_BITS-1:0]                 wd,
  input  logic                                 re,
  input  logic [$clog2(DCO_ROWS*DCO_STEPS)-1:0] ra0,
  input  logic [$clog2(DCO_ROWS*DCO_STEPS)-1:0] ra1,
  output logic [FREQ_BITS-1:0]                 rd0,
  output logic [FREQ_BITS-1:0]                 rd1
);

  localparam int DEPTH = DCO_ROWS * DCO_STEPS;

  logic [FREQ_BITS-1:0] table_mem [DEPTH];
  logic [FREQ_BITS-1:0] rd0_r;
  logic [FREQ_BITS-1:0] rd1_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      table_mem[wa] <= wd;
    end
  end

  // read ports with same-cycle forwarding
  always_ff @(posedge clk) begin
    if (re) begin
      rd0_r <= (we && wa == ra0) ? wd : table_mem[ra0];
      rd1_r <= (we && wa == ra1) ? wd : table_mem[ra1];
    end
  end

  assign rd0 = rd0_r;
  assign rd1 = rd1_r;

endmodule

>>> rtl/cmfr_clk_calc.sv
// cmfr_clk_calc: DCO interpolation and clock source selection for one item
// combinational; the result is registered by the caller
// depends on cmfr_pkg
module cmfr_clk_calc
  import cmfr_pkg::*;
#(
  parameter int FREQ_BITS = FREQ_BITS_DEF
) (
  input  cmfr_ctl_t             ctl,
  input  logic [FREQ_BITS-1:0]  t0,
  input  logic [FREQ_BITS-1:0]  t1,
  output out_item_t             result
);

  localparam int SW = (FREQ_BITS + 5 > 64) ? 64 : FREQ_BITS + 5;
  localparam int WB = (FREQ_BITS > 32) ? FREQ_BITS : 32;
  localparam logic [WB-1:0] FMASK = {WB{1'b1}} >> (WB - FREQ_BITS);

  logic [5:0]           w0;
  logic [SW-1:0]        p0;
  logic [SW-1:0]        p1;
  logic [SW-1:0]        sum;
  logic [FREQ_BITS-1:0] dco;
  logic [WB-1:0]        dco_w;
  logic [WB-1:0]        lf_w;
  logic [WB-1:0]        x2_w;
  logic [WB-1:0]        mclk;
  logic [WB-1:0]        sclk;
  logic [WB-1:0]        aclk;

  // weighted blend of two adjacent steps
  always_comb begin
    w0  = 6'd32 - {1'b0, ctl.mod};
    p0  = SW'(w0) * SW'(t0);
    p1  = SW'(ctl.mod) * SW'(t1);
    sum = p0 + p1;
    dco = ctl.step_last ? t0 : FREQ_BITS'(sum >> 5);
  end

  // source selection and dividers
  always_comb begin
    dco_w = WB'(dco);
    lf_w  = WB'(ctl.lf_hz);
    x2_w  = WB'(ctl.x2_hz);
    aclk  = lf_w >> ctl.div_a;
    mclk  = dco_w;
    case (ctl.sel_m)
      2'd2: begin
        if (ctl.x2_hz != 32'd0 && ctl.xt2_present) begin
          mclk = x2_w;
        end else if (ctl.lf_hz != 32'd0) begin
          mclk = lf_w;
        end
      end
      2'd3: begin
        if (ctl.lf_hz != 32'd0) begin
          mclk = lf_w;
        end
      end
      default: ;
    endcase
    mclk = mclk >> ctl.div_m;
    if (ctl.cpu_off) begin
      mclk = '0;
    end
    sclk = (ctl.sel_s ? x2_w : dco_w) >> ctl.div_s;
    if (ctl.sub_off) begin
      sclk = '0;
    end
  end

  // result item
  always_comb begin
    result.read_data        = ctl.read_data;
    result.aux_clock_hz     = 32'(aclk & FMASK);
    result.main_clock_hz    = 32'(mclk & FMASK);
    result.submain_clock_hz = 32'(sclk & FMASK);
    result.fault_irq        = ctl.irq;
  end

endmodule

>>> test/tb.sv
// tb: self-checking testbench for clock_module_frequency_registers
// checks every result against an in-bench clock predictor, with random idling on both channels
// depends on cmfr_pkg and the rtl top level
module tb;
  import cmfr_pkg::*;

  // commands with no function
  localparam logic [3:0] CMD_SPARE_FIRST = 4'd9;
  localparam logic [3:0] CMD_SPARE_LAST  = 4'd15;
  localparam int TBL_SIZE     = DCO_ROWS_DEF * DCO_STEPS;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 220;
  localparam int SETTLE_GAP   = 6;
  localparam int DRAIN_LIMIT  = 5000;

  typedef struct packed {
    out_item_t val;
    logic      main_ok;
    logic      sub_ok;
  } clk_expect_t;

  typedef struct packed {
    in_item_t   item;
    logic       typed;
    logic [7:0] rd;
    logic       irq;
  } stim_row_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_item_t           in_item   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_item;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [31:0]        pwdata    = '0;
  logic [31:0]        prdata;
  logic               pready;

  // predictor copy of configuration and block state
  logic        plus_v, xhm_v;
  logic [14:0] vlo_v;
  logic [7:0]  dcoctl_q, ctl1_q, ctl2_q, ctl3_q;
  logic [31:0] xt1_q, xt2_q;
  logic        xt2_on_q, cpuoff_q, suboff_q, irq_q;
  logic [31:0] dco_tbl [TBL_SIZE];
  bit          dco_set [TBL_SIZE];

  clk_expect_t expected_clocks[$];
  stim_row_t   dir_rows[$];
  int          errors     = 0;
  int          n_accesses = 0;
  int          n_checked  = 0;
  int          idle_in_pct = 0;
  int          stall_pct   = 0;

  clock_module_frequency_registers dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // crystal range bounds by range select
  function automatic logic [31:0] band_lo(input logic [1:0] s);
    if (s == 2'd1) return 32'd1000000;
    if (s == 2'd2) return 32'd3000000;
    return 32'd400000;
  endfunction

  function automatic logic [31:0] band_hi(input logic [1:0] s);
    if (s == 2'd0) return 32'd1000000;
    if (s == 2'd1) return 32'd3000000;
    return 32'd16000000;
  endfunction

  function automatic void model_reset();
    plus_v   = 1'b1;
    xhm_v    = 1'b1;
    vlo_v    = VLO_RST;
    dcoctl_q = DCOCTL_RST;
    ctl1_q   = CTL1_RST_PLUS;
    ctl2_q   = CTL2_RST;
    ctl3_q   = CTL3_RST;
    xt1_q    = '0;
    xt2_q    = '0;
    xt2_on_q = 1'b0;
    cpuoff_q = 1'b0;
    suboff_q = 1'b0;
    irq_q    = 1'b0;
    foreach (dco_tbl[i]) begin
      dco_tbl[i] = '0;
      dco_set[i] = 1'b0;
    end
  endfunction

  // soft or power-on reset command
  function automatic void restart(input logic por);
    if (ctl3_q[1] && !ctl3_q[0]) irq_q = 1'b0;
    dcoctl_q = DCOCTL_RST;
    if (por) ctl1_q = {CTL1_POR_HI, 4'h0};
    ctl1_q[3:0] = plus_v ? RSEL_RST_PLUS : RSEL_RST_BASIC;
    if (por || plus_v) ctl2_q = CTL2_RST;
    else ctl2_q[3:0] = 4'h0;
    ctl3_q = (por ? 8'h00 : {7'd0, ctl3_q[0]}) | CTL3_RST;
  endfunction

  // recompute fault flag and the aux, main and sub-main clocks from the current state
  function automatic clk_expect_t predict_clocks();
    clk_expect_t e;
    logic [1:0]  lfs, x2s;
    logic [31:0] lf, x2, dco, mclk, sclk;
    logic [7:0]  prev;
    logic [3:0]  rsel;
    logic [2:0]  st;
    logic [4:0]  md;
    logic [6:0]  idx;
    logic [63:0] acc;
    bit          dco_ok, main_dco;
    e    = '0;
    lfs  = ctl3_q[5:4];
    x2s  = ctl3_q[7:6];
    lf   = '0;
    x2   = xt2_q;
    prev = ctl3_q;
    // low-frequency source
    if ((!plus_v || xhm_v) && ctl1_q[6]) begin
      if (xt1_q >= band_lo(lfs) && xt1_q <= band_hi(lfs)) lf = xt1_q;
    end else if (lfs == 2'd0) begin
      if (xt1_q == LF_WATCH_HZ) lf = xt1_q;
    end else if (lfs == 2'd2) begin
      lf = {17'd0, vlo_v};
    end else if (lfs == 2'd3) begin
      if (xt1_q >= LF_EXT_LO && xt1_q <= LF_EXT_HI) lf = xt1_q;
    end
    if (x2 < band_lo(x2s) || x2 > band_hi(x2s)) x2 = '0;
    // xt2 fault flag and interrupt level
    ctl3_q[1] = (x2 == '0) && xt2_on_q;
    if (ctl3_q != prev) irq_q = |ctl3_q[1:0];
    // dco interpolated between two steps
    rsel   = plus_v ? ctl1_q[3:0] : {1'b0, ctl1_q[2:0]};
    st     = dcoctl_q[7:5];
    md     = dcoctl_q[4:0];
    idx    = {rsel, st};
    acc    = {32'd0, dco_tbl[idx]};
    dco_ok = dco_set[idx];
    if (st != 3'd7) begin
      acc = (64'd32 - {59'd0, md}) * {32'd0, dco_tbl[idx]}
          + {59'd0, md} * {32'd0, dco_tbl[idx + 7'd1]};
      acc = acc / 64'd32;
      dco_ok = dco_ok && dco_set[idx + 7'd1];
    end
    dco = acc[31:0];
    e.val.aux_clock_hz = lf >> ctl1_q[5:4];
    // main clock select
    mclk = dco;
    main_dco = 1'b1;
    if (ctl2_q[7:6] == 2'd2) begin
      if (x2 != '0 && xt2_on_q) begin
        mclk = x2;
        main_dco = 1'b0;
      end else if (lf != '0) begin
        mclk = lf;
        main_dco = 1'b0;
      end
    end else if (ctl2_q[7:6] == 2'd3 && lf != '0) begin
      mclk = lf;
      main_dco = 1'b0;
    end
    mclk = mclk >> ctl2_q[5:4];
    if (cpuoff_q) begin
      mclk = '0;
      main_dco = 1'b0;
    end
    // sub-main clock
    sclk = ctl2_q[3] ? x2 : dco;
    sclk = sclk >> ctl2_q[2:1];
    if (suboff_q) sclk = '0;
    e.val.main_clock_hz    = mclk;
    e.val.submain_clock_hz = sclk;
    e.val.fault_irq        = irq_q;
    // a clock built on a table entry not yet loaded is not checked
    e.main_ok = dco_ok || !main_dco;
    e.sub_ok  = dco_ok || ctl2_q[3] || suboff_q;
    return e;
  endfunction

  // apply one access or event, then return the result it gives
  function automatic clk_expect_t apply_access(input in_item_t it);
    clk_expect_t e;
    case (it.command)
      CMD_WRITE: begin
        case (it.reg_addr)
          REG_DCOCTL: dcoctl_q = it.write_data;
          REG_CTL1:   ctl1_q = it.write_data;
          REG_CTL2:   ctl2_q = it.write_data;
          default:    if (plus_v) ctl3_q = {it.write_data[7:2], ctl3_q[1:0]};
        endcase
      end
      CMD_SET_XT1:  xt1_q = it.freq_hz;
      CMD_SET_XT2: begin
        xt2_q    = it.freq_hz;
        xt2_on_q = it.xt2_connected;
      end
      CMD_CPUOFF:   cpuoff_q = it.gate_level;
      CMD_SCG1:     suboff_q = it.gate_level;
      CMD_SOFT_RST: restart(1'b0);
      CMD_POR_RST:  restart(1'b1);
      CMD_LOAD: begin
        dco_tbl[{it.table_row, it.table_step}] = it.freq_hz;
        dco_set[{it.table_row, it.table_step}] = 1'b1;
      end
      default: ;
    endcase
    e = predict_clocks();
    if (it.command == CMD_READ) begin
      case (it.reg_addr)
        REG_DCOCTL: e.val.read_data = dcoctl_q;
        REG_CTL1:   e.val.read_data = ctl1_q;
        REG_CTL2:   e.val.read_data = ctl2_q;
        default:    e.val.read_data = plus_v ? ctl3_q : 8'h00;
      endcase
    end
    return e;
  endfunction

  // offer one item, wait for it to be taken, record its expected result
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    clk_expect_t e;
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_item  = it;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    e = apply_access(it);
    if (typed) begin
      e.val     = want;
      e.main_ok = 1'b1;
      e.sub_ok  = 1'b1;
    end
    expected_clocks.push_back(e);
    n_accesses++;
    @(negedge clk);
  endtask

  // hold off the sender until every result is back
  task automatic drain_results();
    in_valid = 1'b0;
    for (int w = 0; w < DRAIN_LIMIT && expected_clocks.size() != 0; w++) @(negedge clk);
    if (expected_clocks.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_clocks.size());
      errors++;
      expected_clocks.delete();
    end
    repeat (SETTLE_GAP) @(negedge clk);
  endtask

  // register write with read-back
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] want;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      CFG_PLUS: plus_v = val[0];
      CFG_XHM:  xhm_v = val[0];
      default:  vlo_v = val[14:0];
    endcase
    want = (idx == CFG_VLO) ? {17'd0, val[14:0]} : {31'd0, val[0]};
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== want) begin
      $display("%0t: config %0d read-back expected %h, got %h", $time, idx, want, prdata);
      errors++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  function automatic logic [31:0] pick_freq();
    case ($urandom_range(7))
      0: return LF_WATCH_HZ;
      1: return $urandom_range(50000, 10000);
      2: return $urandom_range(1000000, 400000);
      3: return $urandom_range(3000000, 1000000);
      4: return $urandom_range(16000000, 3000000);
      5: begin
        case ($urandom_range(9))
          0: return 32'd399999;
          1: return 32'd400000;
          2: return 32'd1000000;
          3: return 32'd1000001;
          4: return 32'd2999999;
          5: return 32'd3000000;
          6: return 32'd16000000;
          7: return 32'd16000001;
          8: return 32'd9999;
          default: return 32'd50001;
        endcase
      end
      6: return $urandom;
      default: return '0;
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int       pick;
    it.command       = CMD_READ;
    it.reg_addr      = 2'($urandom);
    it.write_data    = 8'($urandom);
    it.freq_hz       = $urandom;
    it.xt2_connected = 1'($urandom);
    it.gate_level    = $urandom_range(3) == 0;
    it.table_row     = 4'($urandom);
    it.table_step    = 3'($urandom);
    pick = $urandom_range(99);
    if (pick < 30) it.command = CMD_WRITE;
    else if (pick < 45) it.command = CMD_READ;
    else if (pick < 55) begin
      it.command = CMD_SET_XT1;
      it.freq_hz = pick_freq();
    end else if (pick < 65) begin
      it.command = CMD_SET_XT2;
      it.freq_hz = pick_freq();
    end else if (pick < 70) it.command = CMD_CPUOFF;
    else if (pick < 75) it.command = CMD_SCG1;
    else if (pick < 78) it.command = CMD_SOFT_RST;
    else if (pick < 80) it.command = CMD_POR_RST;
    else if (pick < 94) it.command = CMD_LOAD;
    else it.command = 4'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
    return it;
  endfunction

  // directed item; the flag drives both xt2_connected and gate_level
  function automatic in_item_t mk(input logic [3:0] cmd, input logic [1:0] addr,
                                  input logic [7:0] wdata, input logic [31:0] freq,
                                  input logic flag);
    in_item_t it;
    it.command       = cmd;
    it.reg_addr      = addr;
    it.write_data    = wdata;
    it.freq_hz       = freq;
    it.xt2_connected = flag;
    it.gate_level    = flag;
    it.table_row     = '1;
    it.table_step    = '1;
    return it;
  endfunction

  function automatic void add_row(input in_item_t it, input logic typed,
                                  input logic [7:0] rd, input logic irq);
    stim_row_t r;
    r.item  = it;
    r.typed = typed;
    r.rd    = rd;
    r.irq   = irq;
    dir_rows.push_back(r);
  endfunction

  // receiver stall
  always @(negedge clk) out_stall = ($urandom_range(99) < stall_pct);

  task automatic cmp_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    clk_expect_t e;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_clocks.size() == 0) begin
        $display("%0t: unexpected result, got %h", $time, out_item);
        errors++;
      end else begin
        e = expected_clocks.pop_front();
        n_checked++;
        cmp_field("read_data", {24'd0, e.val.read_data}, {24'd0, out_item.read_data});
        cmp_field("aux_clock_hz", e.val.aux_clock_hz, out_item.aux_clock_hz);
        if (e.main_ok) cmp_field("main_clock_hz", e.val.main_clock_hz, out_item.main_clock_hz);
        if (e.sub_ok)
          cmp_field("submain_clock_hz", e.val.submain_clock_hz, out_item.submain_clock_hz);
        cmp_field("fault_irq", {31'd0, e.val.fault_irq}, {31'd0, out_item.fault_irq});
      end
    end
  end

  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    in_item_t  it;
    out_item_t want;
    model_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // fill the whole dco table, zero and all-ones at the corners
    for (int r = 0; r < DCO_ROWS_DEF; r++) begin
      for (int s = 0; s < DCO_STEPS; s++) begin
        it = '0;
        it.command    = CMD_LOAD;
        it.table_row  = 4'(r);
        it.table_step = 3'(s);
        it.freq_hz    = $urandom_range(20000000, 60000);
        if (r == 0 && s == 0) it.freq_hz = '0;
        if (r == DCO_ROWS_DEF - 1 && s == DCO_STEPS - 1) it.freq_hz = '1;
        send_item(it, 1'b0, '0);
      end
    end

    // directed part: gate everything, read reset values, fault flag and resets
    add_row(mk(CMD_CPUOFF, REG_DCOCTL, 8'h00, 32'd0, 1'b1), 1'b0, 8'h00, 1'b0);
    add_row(mk(CMD_SCG1, REG_DCOCTL, 8'h00, 32'd0, 1'b1), 1'b0, 8'h00, 1'b0);
    add_row(mk(CMD_READ, REG_DCOCTL, 8'h00, 32'd0, 1'b0), 1'b1, DCOCTL_RST, 1'b0);
    add_row(mk(CMD_READ, REG_CTL1, 8'h00, 32'd0, 1'b0), 1'b1, CTL1_RST_PLUS, 1'b0);
    add_row(mk(CMD_READ, REG_CTL2, 8'h00, 32'd0, 1'b0), 1'b1, CTL2_RST, 1'b0);
    add_row(mk(CMD_READ, REG_CTL3, 8'h00, 32'd0, 1'b0), 1'b1, CTL3_RST, 1'b0);
    add_row(mk(CMD_SPARE_LAST, REG_CTL3, 8'hFF, '1, 1'b1), 1'b1, 8'h00, 1'b0);
    // fault flag bits are kept on a write
    add_row(mk(CMD_WRITE, REG_CTL3, 8'hFF, 32'd0, 1'b0), 1'b0, 8'h00, 1'b0);
    add_row(mk(CMD_READ, REG_CTL3, 8'h00, 32'd0, 1'b0), 1'b1, 8'hFC, 1'b0);
    // xt2 with a source but out of range raises the fault
    add_row(mk(CMD_SET_XT2, REG_DCOCTL, 8'h00, 32'd0, 1'b1), 1'b1, 8'h00, 1'b1);
    add_row(mk(CMD_READ, REG_CTL3, 8'h00, 32'd0, 1'b0), 1'b1, 8'hFE, 1'b1);
    add_row(mk(CMD_SOFT_RST, REG_DCOCTL, 8'h00, 32'd0, 1'b0), 1'b0, 8'h00, 1'b0);
    add_row(mk(CMD_SET_XT2, REG_DCOCTL, 8'h00, 32'd800000, 1'b1), 1'b0, 8'h00, 1'b0);
    add_row(mk(CMD_CPUOFF, REG_DCOCTL, 8'h00, 32'd0, 1'b0), 1'b0, 8'h00, 1'b0);
    add_row(mk(CMD_SCG1, REG_DCOCTL, 8'h00, 32'd0, 1'b0), 1'b0, 8'h00, 1'b0);
    // crystal modes and clock selects
    add_row(mk(CMD_WRITE, REG_CTL1, 8'h40, 32'd0, 1'b0), 1'b0, 8'h00, 1'b0);
    add_row(mk(CMD_SET_XT1, REG_DCOCTL, 8'h00, LF_WATCH_HZ, 1'b0), 1'b0, 8'h00, 1'b0);
    add_row(mk(CMD_WRITE, REG_CTL1, 8'h00, 32'd0, 1'b0), 1'b0, 8'h00, 1'b0);
    add_row(mk(CMD_SET_XT1, REG_DCOCTL, 8'h00, '1, 1'b0), 1'b0, 8'h00, 1'b0);
    add_row(mk(CMD_WRITE, REG_CTL2, 8'h80, 32'd0, 1'b0), 1'b0, 8'h00, 1'b0);
    add_row(mk(CMD_WRITE, REG_DCOCTL, 8'hFF, 32'd0, 1'b0), 1'b0, 8'h00, 1'b0);
    add_row(mk(CMD_WRITE, REG_CTL2, 8'hFF, 32'd0, 1'b0), 1'b0, 8'h00, 1'b0);
    add_row(mk(CMD_WRITE, REG_CTL1, 8'hFF, 32'd0, 1'b0), 1'b0, 8'h00, 1'b0);
    add_row(mk(CMD_POR_RST, REG_DCOCTL, 8'h00, 32'd0, 1'b0), 1'b0, 8'h00, 1'b0);
    add_row(mk(CMD_LOAD, REG_DCOCTL, 8'h00, '1, 1'b1), 1'b0, 8'h00, 1'b0);
    foreach (dir_rows[i]) begin
      want = '0;
      want.read_data = dir_rows[i].rd;
      want.fault_irq = dir_rows[i].irq;
      send_item(dir_rows[i].item, dir_rows[i].typed, want);
    end

    // random part: configuration and idling change per phase
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: begin cfg_write(CFG_PLUS, 1); cfg_write(CFG_XHM, 1); cfg_write(CFG_VLO, 12000); end
        1: begin cfg_write(CFG_PLUS, 0); cfg_write(CFG_XHM, 0); cfg_write(CFG_VLO, 4000); end
        2: begin cfg_write(CFG_PLUS, 1); cfg_write(CFG_XHM, 0); cfg_write(CFG_VLO, 20000); end
        3: begin
          cfg_write(CFG_PLUS, 0);
          cfg_write(CFG_XHM, 1);
          cfg_write(CFG_VLO, $urandom_range(20000, 4000));
        end
        4: begin cfg_write(CFG_PLUS, 1); cfg_write(CFG_XHM, 1); cfg_write(CFG_VLO, 20000); end
        5: begin cfg_write(CFG_PLUS, 0); cfg_write(CFG_XHM, 1); cfg_write(CFG_VLO, 4000); end
        6: begin
          cfg_write(CFG_PLUS, 1);
          cfg_write(CFG_XHM, 0);
          cfg_write(CFG_VLO, $urandom_range(20000, 4000));
        end
        default: begin
          cfg_write(CFG_PLUS, 1);
          cfg_write(CFG_XHM, 1);
          cfg_write(CFG_VLO, 12000);
        end
      endcase
      case (p % 4)
        0: begin idle_in_pct = 0;  stall_pct = 0;  end
        1: begin idle_in_pct = 84; stall_pct = 0;  end
        2: begin idle_in_pct = 0;  stall_pct = 84; end
        default: begin idle_in_pct = 7; stall_pct = 7; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(rand_item(), 1'b0, '0);
    end

    idle_in_pct = 0;
    stall_pct   = 0;
    drain_results();
    $display("covered %0d items over %0d phases of variant, crystal mode, vlo and idling",
             n_accesses, PHASES);
    $display("%0d results compared against the clock predictor", n_checked);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> clock_module_frequency_registers.f
rtl/cmfr_pkg.sv
rtl/cmfr_dco_table.sv
rtl/cmfr_clk_calc.sv
rtl/clock_module_frequency_registers.sv
test/tb.sv
